>>> sv/memory_budget_job_admission_top_assert.svh
// assertion macros for the job admission block
// used by the core module; expects clk and rst in scope
`ifndef MEMORY_BUDGET_JOB_ADMISSION_TOP_ASSERT_SVH
`define MEMORY_BUDGET_JOB_ADMISSION_TOP_ASSERT_SVH

// check a property on every clock edge outside reset
`define MBJA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("mbja assertion failed");

// check a property on every clock edge, reset included
`define MBJA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("mbja assertion failed");

`endif

>>> sv/mbja_pkg.sv
// shared types and constants for the job admission block
// no dependencies
`timescale 1ns / 1ps

package mbja_pkg;

  localparam int ID_W    = 64;
  localparam int TAG_W   = 32;
  localparam int BYTES_W = 48;
  localparam int CNT_OUT_W = 5;

  localparam logic [BYTES_W-1:0] BUDGET_RESET = 48'd268435456;
  localparam logic [BYTES_W-1:0] BYTES_MAX    = {BYTES_W{1'b1}};

  localparam logic [2:0] KIND_SUBMIT   = 3'd0;
  localparam logic [2:0] KIND_CANCEL   = 3'd1;
  localparam logic [2:0] KIND_TAKE     = 3'd2;
  localparam logic [2:0] KIND_FINISH   = 3'd3;
  localparam logic [2:0] KIND_SHUTDOWN = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NONE      = 3'd1;
  localparam logic [2:0] ST_STOPPED   = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;

  typedef struct packed {
    logic [BYTES_W-1:0] est;
    logic               has_key;
    logic [TAG_W-1:0]   tag;
    logic [ID_W-1:0]    id;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  typedef struct packed {
    logic [CNT_OUT_W-1:0] peak_running;
    logic [CNT_OUT_W-1:0] running;
    logic [BYTES_W-1:0]   peak_admitted;
    logic [BYTES_W-1:0]   admitted;
    logic                 given_charged;
    logic                 given_cancelled;
    logic [ID_W-1:0]      given_id;
    logic [2:0]           status;
  } res_t;

  function automatic logic [CNT_OUT_W-1:0] clamp_count(input logic [31:0] c);
    clamp_count = (c > 32'd31) ? 5'd31 : c[CNT_OUT_W-1:0];
  endfunction

endpackage

>>> sv/mbja_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module mbja_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/mbja_core.sv
// admission engine: slot table and pending list in rams, flags in flops
// depends on mbja_pkg, mbja_ram and the assertion macro header
`timescale 1ns / 1ps
`include "memory_budget_job_admission_top_assert.svh"

module mbja_core #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [mbja_pkg::BYTES_W-1:0]  cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    in_kind,
  input  mbja_pkg::slot_t               in_item,
  output logic                          res_valid,
  input  logic                          res_ready,
  output mbja_pkg::res_t                res
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SCAN   = 4'd1;
  localparam logic [3:0] S_END    = 4'd2;
  localparam logic [3:0] S_TK_RDP = 4'd3;
  localparam logic [3:0] S_TK_RDS = 4'd4;
  localparam logic [3:0] S_TK_CHK = 4'd5;
  localparam logic [3:0] S_MV_RD  = 4'd6;
  localparam logic [3:0] S_MV_WR  = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  logic [3:0] state;

  logic [2:0]      kind;
  mbja_pkg::slot_t item;

  logic [TABLE_DEPTH-1:0] valid, listed, canc, running, charged, idmatch;
  logic [CW-1:0] vcount, pcount, runc, peakrun;
  logic [mbja_pkg::BYTES_W-1:0] adm, peak_adm, budget, found_est;
  logic stopping;

  logic [AW:0]   cnt;
  logic          cmp_vld;
  logic [AW-1:0] cmp_idx;
  logic          found, free_found;
  logic [AW-1:0] found_idx, free_idx;

  logic [AW:0]   p;
  logic [AW-1:0] sel;

  logic [2:0]                status;
  logic [mbja_pkg::ID_W-1:0] gid;
  logic                      gc, gch;

  // memories
  mbja_pkg::slot_t slot_rd;
  logic [mbja_pkg::SLOT_W-1:0] slot_rdata;
  logic [AW-1:0] slot_raddr;
  logic          slot_we;
  logic [AW-1:0] pend_rdata, pend_raddr, pend_waddr, pend_wdata;
  logic          pend_we;

  assign slot_rd = mbja_pkg::slot_t'(slot_rdata);

  mbja_ram #(.WIDTH(mbja_pkg::SLOT_W), .DEPTH(TABLE_DEPTH)) u_slot_ram (
    .clk(clk), .we(slot_we), .waddr(free_idx), .wdata(item),
    .raddr(slot_raddr), .rdata(slot_rdata)
  );

  mbja_ram #(.WIDTH(AW), .DEPTH(TABLE_DEPTH)) u_pend_ram (
    .clk(clk), .we(pend_we), .waddr(pend_waddr), .wdata(pend_wdata),
    .raddr(pend_raddr), .rdata(pend_rdata)
  );

  logic [AW:0] p_inc;
  assign p_inc = p + 1'b1;

  always_comb begin
    slot_raddr = (state == S_TK_RDS) ? pend_rdata : cnt[AW-1:0];
    pend_raddr = (state == S_MV_RD) ? p_inc[AW-1:0] : p[AW-1:0];
    slot_we    = (state == S_END) && (kind == mbja_pkg::KIND_SUBMIT);
    pend_we    = slot_we || (state == S_MV_WR);
    pend_waddr = (state == S_MV_WR) ? p[AW-1:0] : pcount[AW-1:0];
    pend_wdata = (state == S_MV_WR) ? pend_rdata : free_idx;
  end

  // take checks
  logic [mbja_pkg::BYTES_W:0]   sum49;
  logic [mbja_pkg::BYTES_W-1:0] sat_sum;
  logic tk_free, tk_fits, tk_alone, tk_ok;
  logic [CW-1:0] runc_inc;

  always_comb begin
    sum49    = {1'b0, adm} + {1'b0, slot_rd.est};
    sat_sum  = sum49[mbja_pkg::BYTES_W] ? mbja_pkg::BYTES_MAX : sum49[mbja_pkg::BYTES_W-1:0];
    tk_free  = canc[sel];
    tk_fits  = sum49 <= {1'b0, budget};
    tk_alone = (runc == '0) && (p == '0);
    tk_ok    = tk_free || tk_fits || tk_alone;
    runc_inc = runc + 1'b1;
  end

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  always_comb begin
    res.status          = status;
    res.given_id        = gid;
    res.given_cancelled = gc;
    res.given_charged   = gch;
    res.admitted        = adm;
    res.peak_admitted   = peak_adm;
    res.running         = mbja_pkg::clamp_count(32'(runc));
    res.peak_running    = mbja_pkg::clamp_count(32'(peakrun));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      valid    <= '0;
      vcount   <= '0;
      pcount   <= '0;
      runc     <= '0;
      peakrun  <= '0;
      adm      <= '0;
      peak_adm <= '0;
      stopping <= 1'b0;
      budget   <= mbja_pkg::BUDGET_RESET;
      cmp_vld  <= 1'b0;
    end else begin
      if (cfg_we) begin
        budget <= cfg_wdata;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            kind       <= in_kind;
            item       <= in_item;
            gid        <= '0;
            gc         <= 1'b0;
            gch        <= 1'b0;
            found      <= 1'b0;
            free_found <= 1'b0;
            idmatch    <= '0;
            cnt        <= '0;
            cmp_vld    <= 1'b0;
            p          <= '0;
            case (in_kind)
              mbja_pkg::KIND_SUBMIT: begin
                if (32'(vcount) >= TABLE_DEPTH || 32'(pcount) >= TABLE_DEPTH) begin
                  status <= mbja_pkg::ST_FULL;
                  state  <= S_DONE;
                end else begin
                  status <= mbja_pkg::ST_OK;
                  state  <= S_SCAN;
                end
              end
              mbja_pkg::KIND_CANCEL, mbja_pkg::KIND_FINISH: begin
                status <= mbja_pkg::ST_OK;
                state  <= S_SCAN;
              end
              mbja_pkg::KIND_TAKE: begin
                if (pcount == '0) begin
                  status <= stopping ? mbja_pkg::ST_STOPPED : mbja_pkg::ST_NONE;
                  state  <= S_DONE;
                end else begin
                  status <= mbja_pkg::ST_OK;
                  state  <= S_TK_RDP;
                end
              end
              mbja_pkg::KIND_SHUTDOWN: begin
                if (!stopping) begin
                  stopping <= 1'b1;
                  canc     <= canc | (valid & listed);
                end
                status <= mbja_pkg::ST_OK;
                state  <= S_DONE;
              end
              default: begin
                status <= mbja_pkg::ST_OK;
                state  <= S_DONE;
              end
            endcase
          end
        end

        // one slot read issued and one compared per cycle
        S_SCAN: begin
          if (32'(cnt) < TABLE_DEPTH) begin
            cmp_vld <= 1'b1;
            cmp_idx <= cnt[AW-1:0];
            cnt     <= cnt + 1'b1;
          end else begin
            cmp_vld <= 1'b0;
            state   <= S_END;
          end
          if (cmp_vld) begin
            case (kind)
              mbja_pkg::KIND_SUBMIT: begin
                if (!valid[cmp_idx] && !free_found) begin
                  free_found <= 1'b1;
                  free_idx   <= cmp_idx;
                end
                if (valid[cmp_idx] && listed[cmp_idx] && !stopping) begin
                  if (item.has_key && slot_rd.has_key && slot_rd.tag == item.tag) begin
                    canc[cmp_idx] <= 1'b1;
                  end
                  if (slot_rd.id == item.id) begin
                    found <= 1'b1;
                  end
                end
              end
              mbja_pkg::KIND_CANCEL: begin
                if (valid[cmp_idx] && listed[cmp_idx] && slot_rd.id == item.id) begin
                  canc[cmp_idx] <= 1'b1;
                  found         <= 1'b1;
                end
              end
              default: begin
                if (valid[cmp_idx] && slot_rd.id == item.id) begin
                  idmatch[cmp_idx] <= 1'b1;
                  if (running[cmp_idx] && !found) begin
                    found     <= 1'b1;
                    found_idx <= cmp_idx;
                    found_est <= slot_rd.est;
                  end
                end
              end
            endcase
          end
        end

        S_END: begin
          state <= S_DONE;
          case (kind)
            mbja_pkg::KIND_SUBMIT: begin
              valid[free_idx]   <= 1'b1;
              canc[free_idx]    <= stopping;
              running[free_idx] <= 1'b0;
              charged[free_idx] <= 1'b0;
              listed[free_idx]  <= !stopping && !found;
              pcount <= pcount + 1'b1;
              vcount <= vcount + 1'b1;
            end
            mbja_pkg::KIND_CANCEL: begin
              if (!found) begin
                status <= mbja_pkg::ST_NOT_FOUND;
              end
            end
            default: begin
              if (!found) begin
                status <= mbja_pkg::ST_NOT_FOUND;
              end else begin
                if (charged[found_idx] && adm >= found_est) begin
                  adm <= adm - found_est;
                end
                if (runc != '0) begin
                  runc <= runc - 1'b1;
                end
                listed             <= listed & ~idmatch;
                valid[found_idx]   <= 1'b0;
                running[found_idx] <= 1'b0;
                charged[found_idx] <= 1'b0;
                vcount             <= vcount - 1'b1;
              end
            end
          endcase
        end

        S_TK_RDP: begin
          state <= S_TK_RDS;
        end

        S_TK_RDS: begin
          sel   <= pend_rdata;
          state <= S_TK_CHK;
        end

        S_TK_CHK: begin
          if (tk_ok) begin
            running[sel] <= 1'b1;
            charged[sel] <= !tk_free;
            if (!tk_free) begin
              adm <= sat_sum;
              if (sat_sum > peak_adm) begin
                peak_adm <= sat_sum;
              end
            end
            runc <= runc_inc;
            if (runc_inc > peakrun) begin
              peakrun <= runc_inc;
            end
            gid <= slot_rd.id;
            gc  <= tk_free;
            gch <= !tk_free;
            if (32'(p) + 32'd1 < 32'(pcount)) begin
              state <= S_MV_RD;
            end else begin
              pcount <= pcount - 1'b1;
              state  <= S_DONE;
            end
          end else if (32'(p) + 32'd1 < 32'(pcount)) begin
            p     <= p_inc;
            state <= S_TK_RDP;
          end else begin
            status <= mbja_pkg::ST_NONE;
            state  <= S_DONE;
          end
        end

        // close the gap in the pending list one entry at a time
        S_MV_RD: begin
          state <= S_MV_WR;
        end

        S_MV_WR: begin
          p <= p_inc;
          if (32'(p) + 32'd2 < 32'(pcount)) begin
            state <= S_MV_RD;
          end else begin
            pcount <= pcount - 1'b1;
            state  <= S_DONE;
          end
        end

        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `MBJA_ASSERT(a_peak_bytes, peak_adm >= adm)
  `MBJA_ASSERT(a_peak_run, peakrun >= runc)
  `MBJA_ASSERT(a_pend_valid, pcount <= vcount)
  `MBJA_ASSERT(a_run_bound, 32'(runc) <= TABLE_DEPTH)

endmodule

>>> sv/memory_budget_job_admission_top.sv
// submit, cancel and finish scan every slot (one slot read each); take reads each pending entry
// tried and its slot, then moves later entries up; other kinds go straight to the result
// sequential: the next word is taken in the cycle after the result enters the output register,
// even while it waits there, so a new word is never taken while one is still in the core
// rst is synchronous: table empty, counts and peaks zero, budget 256 MiB; no clearing pass
// depends on mbja_pkg and mbja_core
`timescale 1ns / 1ps

module memory_budget_job_admission_top #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [47:0]  cfg_wdata,    // byte budget
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [151:0] s_tdata,      // job_id, key_present, key_tag, estimate in bytes
  input  logic [2:0]   s_tuser,      // kind
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [175:0] m_tdata,      // given_job_id, given_cancelled, given_charged,
                                     // admitted_total, peak_admitted_total,
                                     // running_jobs, peak_running_jobs
  output logic [2:0]   m_tuser       // status
);

  mbja_pkg::slot_t in_item;
  mbja_pkg::res_t  res;
  logic            res_valid, res_ready;

  always_comb begin
    in_item.id      = s_tdata[63:0];
    in_item.has_key = s_tdata[64];
    in_item.tag     = s_tdata[96:65];
    in_item.est     = s_tdata[144:97];
  end

  mbja_core #(.TABLE_DEPTH(TABLE_DEPTH)) u_core (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(s_tvalid), .in_ready(s_tready),
    .in_kind(s_tuser), .in_item(in_item),
    .res_valid(res_valid), .res_ready(res_ready), .res(res)
  );

  // output register
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tuser <= res.status;
      m_tdata <= {4'd0, res.peak_running, res.running, res.peak_admitted, res.admitted,
                  res.given_charged, res.given_cancelled, res.given_id};
    end
  end

endmodule

>>> sim/memory_budget_job_admission_top_tb.sv
// self-checking testbench for the job admission block: stream words in, results
// compared field by field against a cycle-free predictor held in a small scoreboard class
// depends on mbja_pkg and memory_budget_job_admission_top
`timescale 1ns / 1ps

module memory_budget_job_admission_top_tb;

  localparam int DEPTH = 16;
  localparam logic [2:0] KIND_SPARE_LO = 3'd5;
  localparam logic [2:0] KIND_SPARE_MID = 3'd6;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 120;

  class admission_scoreboard;
    logic [mbja_pkg::BYTES_W-1:0] budget;
    bit                           valid[DEPTH];
    logic [mbja_pkg::ID_W-1:0]    job_id[DEPTH];
    logic [mbja_pkg::TAG_W-1:0]   tag_of[DEPTH];
    bit                           has_key[DEPTH];
    logic [mbja_pkg::BYTES_W-1:0] est_of[DEPTH];
    bit                           cancelled[DEPTH];
    bit                           running[DEPTH];
    bit                           charged[DEPTH];
    bit                           listed[DEPTH];
    int                           pend_slot[DEPTH];
    int                           pend_cnt;
    logic [mbja_pkg::BYTES_W-1:0] adm_bytes, peak_bytes;
    int                           run_cnt, peak_run;
    bit                           stopping;
    mbja_pkg::res_t               expected_q[$];
    int                           errors;

    function new();
      budget = mbja_pkg::BUDGET_RESET;
      for (int i = 0; i < DEPTH; i++) valid[i] = 0;
      pend_cnt = 0;
      adm_bytes = '0;
      peak_bytes = '0;
      run_cnt = 0;
      peak_run = 0;
      stopping = 0;
      errors = 0;
    endfunction

    function int find_listed(logic [mbja_pkg::ID_W-1:0] id);
      for (int i = 0; i < DEPTH; i++)
        if (valid[i] && listed[i] && job_id[i] == id) return i;
      return -1;
    endfunction

    // id of some running job, for finishes that hit; id kept when none runs
    function bit running_id(inout logic [mbja_pkg::ID_W-1:0] id);
      int n;
      int pick;
      n = 0;
      for (int i = 0; i < DEPTH; i++) if (valid[i] && running[i]) n++;
      if (n == 0) return 0;
      pick = $urandom_range(0, n - 1);
      for (int i = 0; i < DEPTH; i++)
        if (valid[i] && running[i]) begin
          if (pick == 0) begin
            id = job_id[i];
            return 1;
          end
          pick--;
        end
      return 0;
    endfunction

    function void note(logic [2:0] kind, logic [mbja_pkg::ID_W-1:0] id, logic kp,
                       logic [mbja_pkg::TAG_W-1:0] tag, logic [mbja_pkg::BYTES_W-1:0] est);
      mbja_pkg::res_t r;
      int fs;
      int s;
      int idx;
      bit hit;
      logic [mbja_pkg::BYTES_W:0] sum;
      r = '0;
      r.status = mbja_pkg::ST_OK;
      case (kind)
        mbja_pkg::KIND_SUBMIT: begin
          fs = -1;
          for (int i = DEPTH - 1; i >= 0; i--) if (!valid[i]) fs = i;
          if (fs < 0 || pend_cnt >= DEPTH) begin
            r.status = mbja_pkg::ST_FULL;
          end else begin
            listed[fs] = 0;
            if (!stopping) begin
              if (kp)
                for (int i = 0; i < DEPTH; i++)
                  if (valid[i] && listed[i] && has_key[i] && tag_of[i] == tag)
                    cancelled[i] = 1;
              listed[fs] = (find_listed(id) < 0);
            end
            valid[fs] = 1;
            job_id[fs] = id;
            tag_of[fs] = tag;
            has_key[fs] = kp;
            est_of[fs] = est;
            cancelled[fs] = stopping;
            running[fs] = 0;
            charged[fs] = 0;
            pend_slot[pend_cnt] = fs;
            pend_cnt++;
          end
        end
        mbja_pkg::KIND_CANCEL: begin
          idx = find_listed(id);
          if (idx < 0) r.status = mbja_pkg::ST_NOT_FOUND;
          else cancelled[idx] = 1;
        end
        mbja_pkg::KIND_TAKE: begin
          if (stopping && pend_cnt == 0) begin
            r.status = mbja_pkg::ST_STOPPED;
          end else begin
            r.status = mbja_pkg::ST_NONE;
            hit = 0;
            for (int p = 0; p < pend_cnt && !hit; p++) begin
              s = pend_slot[p];
              sum = {1'b0, adm_bytes} + {1'b0, est_of[s]};
              if (cancelled[s] || sum <= {1'b0, budget} || (run_cnt == 0 && p == 0)) begin
                hit = 1;
                for (int q = p; q < pend_cnt - 1; q++) pend_slot[q] = pend_slot[q + 1];
                pend_cnt--;
                running[s] = 1;
                charged[s] = !cancelled[s];
                if (charged[s]) begin
                  adm_bytes = sum[mbja_pkg::BYTES_W] ? mbja_pkg::BYTES_MAX
                                                     : sum[mbja_pkg::BYTES_W-1:0];
                  if (adm_bytes > peak_bytes) peak_bytes = adm_bytes;
                end
                run_cnt++;
                if (run_cnt > peak_run) peak_run = run_cnt;
                r.status = mbja_pkg::ST_OK;
                r.given_id = job_id[s];
                r.given_cancelled = cancelled[s];
                r.given_charged = charged[s];
              end
            end
          end
        end
        mbja_pkg::KIND_FINISH: begin
          s = -1;
          for (int i = DEPTH - 1; i >= 0; i--)
            if (valid[i] && running[i] && job_id[i] == id) s = i;
          if (s < 0) begin
            r.status = mbja_pkg::ST_NOT_FOUND;
          end else begin
            if (charged[s] && adm_bytes >= est_of[s]) adm_bytes = adm_bytes - est_of[s];
            if (run_cnt > 0) run_cnt--;
            for (int i = 0; i < DEPTH; i++) if (valid[i] && job_id[i] == id) listed[i] = 0;
            valid[s] = 0;
            running[s] = 0;
            charged[s] = 0;
          end
        end
        mbja_pkg::KIND_SHUTDOWN: begin
          if (!stopping) begin
            stopping = 1;
            for (int i = 0; i < DEPTH; i++) if (valid[i] && listed[i]) cancelled[i] = 1;
          end
        end
        default: ;
      endcase
      r.admitted = adm_bytes;
      r.peak_admitted = peak_bytes;
      r.running = mbja_pkg::clamp_count(32'(run_cnt));
      r.peak_running = mbja_pkg::clamp_count(32'(peak_run));
      expected_q.insert(expected_q.size(), r);
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task check(logic [2:0] st, logic [175:0] d);
      mbja_pkg::res_t e;
      if (expected_q.size() == 0) begin
        report("result word with nothing expected");
        return;
      end
      e = expected_q.pop_front();
      if (st !== e.status)
        report($sformatf("status %0d, expected %0d", st, e.status));
      if (d[63:0] !== e.given_id)
        report($sformatf("given_job_id %h, expected %h", d[63:0], e.given_id));
      if (d[64] !== e.given_cancelled)
        report($sformatf("given_cancelled %b, expected %b", d[64], e.given_cancelled));
      if (d[65] !== e.given_charged)
        report($sformatf("given_charged %b, expected %b", d[65], e.given_charged));
      if (d[113:66] !== e.admitted)
        report($sformatf("admitted_total %h, expected %h", d[113:66], e.admitted));
      if (d[161:114] !== e.peak_admitted)
        report($sformatf("peak_admitted_total %h, expected %h", d[161:114], e.peak_admitted));
      if (d[166:162] !== e.running)
        report($sformatf("running_jobs %0d, expected %0d", d[166:162], e.running));
      if (d[171:167] !== e.peak_running)
        report($sformatf("peak_running_jobs %0d, expected %0d", d[171:167], e.peak_running));
    endtask
  endclass

  logic         clk;
  logic         rst;
  logic         cfg_we;
  logic [47:0]  cfg_wdata;
  logic         s_tvalid;
  logic         s_tready;
  logic [151:0] s_tdata;
  logic [2:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [175:0] m_tdata;
  logic [2:0]   m_tuser;

  admission_scoreboard sb;
  bit tx_idle;
  bit rx_idle;
  bit long_hold;
  int quiet_cycles;
  logic [mbja_pkg::ID_W-1:0] id_pool[8];
  logic [mbja_pkg::TAG_W-1:0] tag_pool[4];

  memory_budget_job_admission_top #(.TABLE_DEPTH(DEPTH)) i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    m_tready <= 1'b0;
    forever begin
      if (long_hold) begin
        m_tready <= 1'b0;
        repeat (300) @(posedge clk);
        long_hold = 0;
      end else if (rx_idle && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check(m_tuser, m_tdata);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task send_word(logic [2:0] kind, logic [mbja_pkg::ID_W-1:0] id, logic kp,
                 logic [mbja_pkg::TAG_W-1:0] tag, logic [mbja_pkg::BYTES_W-1:0] est);
    if (tx_idle && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {7'b0, est, tag, kp, id};
    s_tuser <= kind;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note(kind, id, kp, tag, est);
  endtask

  // stop offering and let every result come back before touching the register
  task drain_idle;
    s_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task write_budget(logic [mbja_pkg::BYTES_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    sb.budget = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task random_word(bit allow_shutdown);
    logic [mbja_pkg::ID_W-1:0] id;
    logic [mbja_pkg::TAG_W-1:0] tag;
    logic [mbja_pkg::BYTES_W-1:0] est;
    logic [2:0] kind;
    int sel;
    sel = $urandom_range(0, 99);
    id = ($urandom_range(0, 9) < 7) ? id_pool[$urandom_range(0, 7)] : {$urandom, $urandom};
    tag = ($urandom_range(0, 9) < 6) ? tag_pool[$urandom_range(0, 3)] : $urandom;
    case ($urandom_range(0, 9))
      0: est = '0;
      1: est = mbja_pkg::BYTES_MAX;
      2: est = 48'({$urandom, $urandom});
      default: est = 48'($urandom_range(0, 32'h0800_0000));
    endcase
    if (sel < 38) kind = mbja_pkg::KIND_SUBMIT;
    else if (sel < 50) kind = mbja_pkg::KIND_CANCEL;
    else if (sel < 74) kind = mbja_pkg::KIND_TAKE;
    else if (sel < 96) kind = mbja_pkg::KIND_FINISH;
    else if (sel < 98 || !allow_shutdown)
      kind = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
    else kind = mbja_pkg::KIND_SHUTDOWN;
    if (kind == mbja_pkg::KIND_FINISH && $urandom_range(0, 3) != 0) void'(sb.running_id(id));
    send_word(kind, id, 1'($urandom_range(0, 1)), tag, est);
  endtask

  initial begin
    logic [mbja_pkg::BYTES_W-1:0] budgets[5];
    sb = new();
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= mbja_pkg::KIND_SUBMIT;
    tx_idle = 1;
    rx_idle = 1;
    long_hold = 0;
    id_pool[0] = '0;
    id_pool[1] = '1;
    for (int i = 2; i < 8; i++) id_pool[i] = {$urandom, $urandom};
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    tag_pool[2] = $urandom;
    tag_pool[3] = $urandom;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes, duplicates, key coalescing, every kind but shutdown
    send_word(mbja_pkg::KIND_TAKE, '0, 1'b0, '0, '0);
    send_word(mbja_pkg::KIND_SUBMIT, '0, 1'b1, '0, '0);
    send_word(mbja_pkg::KIND_SUBMIT, '1, 1'b1, '1, mbja_pkg::BYTES_MAX);
    send_word(mbja_pkg::KIND_SUBMIT, '0, 1'b1, '1, 48'd1000);
    send_word(mbja_pkg::KIND_SUBMIT, id_pool[2], 1'b0, '1, 48'd5);
    send_word(mbja_pkg::KIND_CANCEL, '0, 1'b0, '0, '0);
    send_word(mbja_pkg::KIND_CANCEL, id_pool[3], 1'b0, '0, '0);
    send_word(mbja_pkg::KIND_TAKE, '0, 1'b0, '0, '0);
    send_word(mbja_pkg::KIND_TAKE, '0, 1'b0, '0, '0);
    send_word(mbja_pkg::KIND_TAKE, '0, 1'b0, '0, '0);
    send_word(mbja_pkg::KIND_TAKE, '0, 1'b0, '0, '0);
    send_word(mbja_pkg::KIND_TAKE, '0, 1'b0, '0, '0);
    send_word(mbja_pkg::KIND_FINISH, '1, 1'b0, '0, '0);
    send_word(mbja_pkg::KIND_FINISH, id_pool[4], 1'b0, '0, '0);
    send_word(mbja_pkg::KIND_FINISH, '0, 1'b0, '0, '0);
    send_word(mbja_pkg::KIND_TAKE, '0, 1'b0, '0, '0);
    send_word(KIND_SPARE_LO, '1, 1'b1, '1, mbja_pkg::BYTES_MAX);
    send_word(KIND_SPARE_MID, '0, 1'b0, '0, '0);
    send_word(KIND_SPARE_HI, '0, 1'b0, '0, '0);
    drain_idle();

    budgets[0] = '0;
    budgets[1] = mbja_pkg::BYTES_MAX;
    budgets[2] = 48'h0000_1000_0000 + 48'($urandom_range(0, 32'hffff));
    budgets[3] = 48'({$urandom, $urandom});
    budgets[4] = 48'h0000_0800_0000;
    for (int ph = 0; ph < 5; ph++) begin
      write_budget(budgets[ph]);
      if (ph == 2) long_hold = 1;
      // stretches with no idling on either side
      tx_idle = (ph != 3);
      rx_idle = (ph != 3);
      for (int n = 0; n < 120; n++) random_word(0);
      drain_idle();
    end

    // last part: no idling, shutdown reachable
    tx_idle = 0;
    rx_idle = 0;
    for (int n = 0; n < 100; n++) random_word(n > 40);
    send_word(mbja_pkg::KIND_SHUTDOWN, '0, 1'b0, '0, '0);
    send_word(mbja_pkg::KIND_SHUTDOWN, '0, 1'b0, '0, '0);
    for (int n = 0; n < 30; n++) random_word(1);
    for (int n = 0; n < 20; n++) send_word(mbja_pkg::KIND_TAKE, '0, 1'b0, '0, '0);
    drain_idle();

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
